### design/mce_pkg.sv
// Shared constants, field layout and controller/datapath interface types of the chord expander.
package mce_pkg;

    localparam int CHORD_SLOTS = 4;
    localparam int SEMITONES   = 12;
    localparam int TABLE_DEPTH = SEMITONES * CHORD_SLOTS;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = (CHORD_SLOTS > 1) ? $clog2(CHORD_SLOTS) : 1;
    localparam int PC_W        = $clog2(SEMITONES);

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 3;
    localparam int TIME_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int OFF_W    = 5;
    localparam int GAIN_W   = 8;
    localparam int NOTE_W   = 10;
    localparam int PROD_W   = 2 * BYTE_W;
    localparam int Q_FRAC   = 6;
    localparam int VEL_W    = PROD_W - Q_FRAC;

    // Input item layout in s_tdata, lowest bits first.
    localparam int S_STATUS_LSB = 0;
    localparam int S_KEY_LSB    = S_STATUS_LSB + BYTE_W;
    localparam int S_LEVEL_LSB  = S_KEY_LSB + BYTE_W;
    localparam int S_COUNT_LSB  = S_LEVEL_LSB + BYTE_W;
    localparam int S_TIME_LSB   = S_COUNT_LSB + COUNT_W;
    localparam int S_INDEX_LSB  = S_TIME_LSB + TIME_W;
    localparam int S_OFF_LSB    = S_INDEX_LSB + INDEX_W;
    localparam int S_GAIN_LSB   = S_OFF_LSB + OFF_W;
    localparam int S_USED_W     = S_GAIN_LSB + GAIN_W;
    localparam int S_DATA_W     = ((S_USED_W + 7) / 8) * 8;

    // Result item layout in m_tdata, lowest bits first.
    localparam int M_USED_W     = 3 * BYTE_W + COUNT_W + TIME_W;
    localparam int M_DATA_W     = ((M_USED_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]  NOTE_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0]  NOTE_MATCH = 8'h80;
    localparam logic [COUNT_W-1:0] SHORT_MSG  = 3'd2;
    localparam logic [VEL_W-1:0]   VEL_MAX    = VEL_W'(127);
    localparam logic [NOTE_W-1:0]  NOTE_MAX   = NOTE_W'(127);
    localparam logic [GAIN_W-1:0]  GAIN_UNITY = 8'd64;
    localparam logic [GAIN_W-1:0]  GAIN_MIN   = 8'd32;
    localparam logic [GAIN_W-1:0]  GAIN_MAX   = 8'd128;
    localparam logic [OFF_W-1:0]   OFF_RESET  = '0;

    // Reciprocal of twelve for an 8-bit key: key / 12 == (key * 171) >> 11.
    localparam logic [PROD_W-1:0]  PC_RECIP   = 16'd171;
    localparam int                 PC_SHIFT   = 11;

    typedef enum logic [OP_W-1:0] {
        OP_EVENT      = 2'd0,
        OP_WRITE_OFF  = 2'd1,
        OP_WRITE_GAIN = 2'd2,
        OP_UNUSED     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_NOTE,
        KIND_PASS
    } kind_t;

    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  keep_any;
        logic  keep_last;
        logic  out_free;
    } sts_t;

endpackage

### design/mce_table.sv
// Chord slot table: offset and gain memories with per-entry valid bits and registered reads.
module mce_table import mce_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     off_we,
    input  logic                     gain_we,
    input  logic [TBL_AW-1:0]        wr_addr,
    input  logic signed [OFF_W-1:0]  wr_off,
    input  logic [GAIN_W-1:0]        wr_gain,
    input  logic [TBL_AW-1:0]        rd_addr,
    output logic signed [OFF_W-1:0]  rd_off,
    output logic [GAIN_W-1:0]        rd_gain
);

    logic signed [OFF_W-1:0] off_mem  [TABLE_DEPTH];
    logic [GAIN_W-1:0]       gain_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  off_vld_reg;
    logic [TABLE_DEPTH-1:0]  gain_vld_reg;
    logic signed [OFF_W-1:0] rd_off_reg;
    logic [GAIN_W-1:0]       rd_gain_reg;
    logic                    rd_off_vld_reg;
    logic                    rd_gain_vld_reg;

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[wr_addr] <= wr_off;
        end
        if (gain_we) begin
            gain_mem[wr_addr] <= wr_gain;
        end
        rd_off_reg  <= off_mem[rd_addr];
        rd_gain_reg <= gain_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_vld_reg     <= '0;
            gain_vld_reg    <= '0;
            rd_off_vld_reg  <= 1'b0;
            rd_gain_vld_reg <= 1'b0;
        end else begin
            if (off_we) begin
                off_vld_reg[wr_addr] <= 1'b1;
            end
            if (gain_we) begin
                gain_vld_reg[wr_addr] <= 1'b1;
            end
            rd_off_vld_reg  <= off_vld_reg[rd_addr];
            rd_gain_vld_reg <= gain_vld_reg[rd_addr];
        end
    end

    assign rd_off  = rd_off_vld_reg  ? rd_off_reg  : OFF_RESET;
    assign rd_gain = rd_gain_vld_reg ? rd_gain_reg : GAIN_UNITY;

endmodule

### design/mce_datapath.sv
// Datapath: input decode, table access, slot evaluation, result buffer and output register.
module mce_datapath import mce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]     s_tuser,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic [BYTE_W-1:0]   in_status;
    logic [BYTE_W-1:0]   in_key;
    logic [BYTE_W-1:0]   in_level;
    logic [COUNT_W-1:0]  in_count;
    logic [TIME_W-1:0]   in_time;
    logic [INDEX_W-1:0]  in_index;
    logic signed [OFF_W-1:0] in_off;
    logic [GAIN_W-1:0]   in_gain;
    logic [GAIN_W-1:0]   sat_gain;
    logic                idx_ok;
    logic                is_note;
    logic [PROD_W-1:0]   pc_prod;
    logic [BYTE_W-1:0]   pc_rem;
    logic [PC_W-1:0]     pitch_class;

    logic [BYTE_W-1:0]   status_reg;
    logic [BYTE_W-1:0]   key_reg;
    logic [BYTE_W-1:0]   level_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TBL_AW-1:0]   base_reg;

    logic [TBL_AW-1:0]   rd_addr;
    logic signed [OFF_W-1:0] rd_off;
    logic [GAIN_W-1:0]   rd_gain;

    logic                eval_vld_reg;
    logic [SLOT_W-1:0]   eval_slot_reg;
    logic signed [OFF_W-1:0] root_reg;
    logic signed [NOTE_W-1:0] note_sum;
    logic [PROD_W-1:0]   vel_prod;
    logic [VEL_W-1:0]    vel_raw;
    logic                slot_ok;

    logic [CHORD_SLOTS-1:0] keep_reg;
    logic [BYTE_W-1:0]   key_buf_reg [CHORD_SLOTS];
    logic [BYTE_W-1:0]   vel_buf_reg [CHORD_SLOTS];
    logic [SLOT_W-1:0]   sel;

    logic                out_vld_reg;
    logic                out_last_reg;
    logic [BYTE_W-1:0]   out_status_reg;
    logic [BYTE_W-1:0]   out_key_reg;
    logic [BYTE_W-1:0]   out_vel_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [TIME_W-1:0]   out_time_reg;

    assign in_status = s_tdata[S_STATUS_LSB +: BYTE_W];
    assign in_key    = s_tdata[S_KEY_LSB    +: BYTE_W];
    assign in_level  = s_tdata[S_LEVEL_LSB  +: BYTE_W];
    assign in_count  = s_tdata[S_COUNT_LSB  +: COUNT_W];
    assign in_time   = s_tdata[S_TIME_LSB   +: TIME_W];
    assign in_index  = s_tdata[S_INDEX_LSB  +: INDEX_W];
    assign in_off    = s_tdata[S_OFF_LSB    +: OFF_W];
    assign in_gain   = s_tdata[S_GAIN_LSB   +: GAIN_W];

    assign idx_ok   = 32'(in_index) < TABLE_DEPTH;
    assign sat_gain = (in_gain < GAIN_MIN) ? GAIN_MIN :
                      (in_gain > GAIN_MAX) ? GAIN_MAX : in_gain;
    assign is_note  = (in_count > SHORT_MSG) && ((in_status & NOTE_MASK) == NOTE_MATCH);

    assign pc_prod     = PROD_W'(in_key) * PC_RECIP;
    assign pc_rem      = in_key - BYTE_W'((pc_prod >> PC_SHIFT) * SEMITONES);
    assign pitch_class = pc_rem[PC_W-1:0];

    assign sts.kind = (s_tuser != OP_EVENT) ? KIND_NONE :
                      is_note ? KIND_NOTE : KIND_PASS;

    assign rd_addr = TBL_AW'(base_reg + TBL_AW'(cmd.rd_slot));

    mce_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .off_we  (cmd.accept && s_tuser == OP_WRITE_OFF && idx_ok),
        .gain_we (cmd.accept && s_tuser == OP_WRITE_GAIN && idx_ok),
        .wr_addr (TBL_AW'(in_index)),
        .wr_off  (in_off),
        .wr_gain (sat_gain),
        .rd_addr (rd_addr),
        .rd_off  (rd_off),
        .rd_gain (rd_gain)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            status_reg <= in_status;
            key_reg    <= in_key;
            level_reg  <= in_level;
            count_reg  <= in_count;
            time_reg   <= in_time;
            base_reg   <= TBL_AW'(pitch_class * CHORD_SLOTS);
        end
    end

    // Slot evaluation runs in the cycle after the table read is issued.
    assign note_sum = $signed({2'b00, key_reg}) + NOTE_W'(rd_off);
    assign vel_prod = PROD_W'(rd_gain) * PROD_W'(level_reg);
    assign vel_raw  = vel_prod[PROD_W-1:Q_FRAC];
    assign slot_ok  = !(eval_slot_reg != '0 && rd_off == root_reg)
                      && !note_sum[NOTE_W-1] && (note_sum <= $signed(NOTE_MAX))
                      && (vel_raw != '0);

    always_comb begin
        sel = '0;
        for (int i = CHORD_SLOTS - 1; i >= 0; i--) begin
            if (keep_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign sts.keep_any  = keep_reg != '0;
    assign sts.keep_last = (keep_reg & (keep_reg - 1'b1)) == '0;
    assign sts.out_free  = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (eval_vld_reg) begin
            key_buf_reg[eval_slot_reg] <= note_sum[BYTE_W-1:0];
            vel_buf_reg[eval_slot_reg] <= (vel_raw > VEL_MAX) ? BYTE_W'(VEL_MAX)
                                                               : vel_raw[BYTE_W-1:0];
            if (eval_slot_reg == '0) begin
                root_reg <= rd_off;
            end
        end else if (cmd.accept) begin
            key_buf_reg[0] <= in_key;
            vel_buf_reg[0] <= in_level;
        end
        if (cmd.emit) begin
            out_status_reg <= status_reg;
            out_key_reg    <= key_buf_reg[sel];
            out_vel_reg    <= vel_buf_reg[sel];
            out_count_reg  <= count_reg;
            out_time_reg   <= time_reg;
            out_last_reg   <= sts.keep_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_vld_reg  <= 1'b0;
            eval_slot_reg <= '0;
            keep_reg      <= '0;
            out_vld_reg   <= 1'b0;
        end else begin
            eval_vld_reg  <= cmd.rd_en;
            eval_slot_reg <= cmd.rd_slot;
            if (cmd.accept) begin
                keep_reg <= (sts.kind == KIND_PASS) ? CHORD_SLOTS'(1) : '0;
            end else if (eval_vld_reg) begin
                keep_reg[eval_slot_reg] <= slot_ok;
            end else if (cmd.emit) begin
                keep_reg[sel] <= 1'b0;
            end
            if (cmd.emit) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_time_reg, out_count_reg, out_vel_reg, out_key_reg,
                                 out_status_reg});

endmodule

### design/mce_ctrl.sv
// Controller state machine: input acceptance, slot read sequence and result emission.
module mce_ctrl import mce_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SLOT_W-1:0] rd_cnt_reg;
    logic [SLOT_W-1:0] rd_cnt_next;
    logic              ready_reg;

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmd.accept  = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.rd_slot = rd_cnt_reg;
        cmd.emit    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid && ready_reg;
                if (cmd.accept) begin
                    rd_cnt_next = '0;
                    case (sts.kind)
                        KIND_NOTE: state_next = ST_READ;
                        KIND_PASS: state_next = ST_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                if (rd_cnt_reg == SLOT_W'(CHORD_SLOTS - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.keep_any) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.keep_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
            ready_reg  <= 1'b1;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            ready_reg  <= state_next == ST_IDLE;
        end
    end

    assign s_tready = ready_reg;

endmodule

### design/midi_chord_expander.sv
// Top level of the MIDI chord expander: controller, datapath and checks.
// After a table write or an ignored item the block is ready again in the next cycle.
// A passed event is loaded into the output register once that register is free, and only then is the block ready again.
// A note event reads its CHORD_SLOTS entries, one per cycle, then emits one result per cycle
// while the output register is free; a note event with no kept result emits nothing.
// Reset returns every slot to zero offset and unity gain at once and empties the output.
module midi_chord_expander import mce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // status_byte, key_byte, level_byte, byte_count, frame_time, table_index,
    // write_offset, write_gain, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_status, out_key, out_level, out_count, out_time, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    cmd_t cmd;
    sts_t sts;

    mce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mce_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_busy_after_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_EVENT) |=> !s_tready)
        else $error("Input accepted while an event is still in work.");

    a_no_work_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.rd_en || cmd.emit))
        else $error("Table read or emission while the block is ready.");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (sts.out_free && sts.keep_any))
        else $error("Emission without a free output register or a kept slot.");

endmodule

### tb/sv/chord_scoreboard.sv
// Scoreboard of the chord expander: predicts the result items and checks the output channel.
module chord_scoreboard import mce_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]     s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  key;
        logic [BYTE_W-1:0]  level;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
        logic               last;
    } chord_note_t;

    logic signed [OFF_W-1:0] chord_off  [TABLE_DEPTH];
    logic [GAIN_W-1:0]       chord_gain [TABLE_DEPTH];
    chord_note_t             expected_notes[$];

    function automatic void expand_item(opcode_t op, logic [S_DATA_W-1:0] d);
        logic [BYTE_W-1:0]       status;
        logic [BYTE_W-1:0]       key;
        logic [BYTE_W-1:0]       level;
        logic [COUNT_W-1:0]      count;
        logic [TIME_W-1:0]       stamp;
        logic [INDEX_W-1:0]      idx;
        logic signed [OFF_W-1:0] woff;
        logic [GAIN_W-1:0]       wgain;
        chord_note_t             run [CHORD_SLOTS];
        int                      base;
        int                      root_off;
        int                      off;
        int                      note;
        int                      vel;
        int                      n;
        status = d[S_STATUS_LSB +: BYTE_W];
        key    = d[S_KEY_LSB +: BYTE_W];
        level  = d[S_LEVEL_LSB +: BYTE_W];
        count  = d[S_COUNT_LSB +: COUNT_W];
        stamp  = d[S_TIME_LSB +: TIME_W];
        idx    = d[S_INDEX_LSB +: INDEX_W];
        woff   = d[S_OFF_LSB +: OFF_W];
        wgain  = d[S_GAIN_LSB +: GAIN_W];
        n = 0;
        case (op)
            OP_WRITE_OFF: begin
                if (idx < TABLE_DEPTH) chord_off[idx] = woff;
            end
            OP_WRITE_GAIN: begin
                if (idx < TABLE_DEPTH) begin
                    chord_gain[idx] = (wgain < GAIN_MIN) ? GAIN_MIN :
                                      (wgain > GAIN_MAX) ? GAIN_MAX : wgain;
                end
            end
            OP_EVENT: begin
                if (count > SHORT_MSG && (status & NOTE_MASK) == NOTE_MATCH) begin
                    base = (int'(key) % SEMITONES) * CHORD_SLOTS;
                    root_off = int'(chord_off[base]);
                    for (int s = 0; s < CHORD_SLOTS; s++) begin
                        off = int'(chord_off[base + s]);
                        note = int'(key) + off;
                        vel = (int'(chord_gain[base + s]) * int'(level)) >> Q_FRAC;
                        if (!(s > 0 && off == root_off) && note >= 0 && note <= 127
                                && vel >= 1) begin
                            run[n] = '{status, note[BYTE_W-1:0],
                                       (vel > 127) ? 8'd127 : vel[BYTE_W-1:0],
                                       count, stamp, 1'b0};
                            n++;
                        end
                    end
                end else begin
                    run[0] = '{status, key, level, count, stamp, 1'b0};
                    n = 1;
                end
                for (int i = 0; i < n; i++) begin
                    run[i].last = (i == n - 1);
                    expected_notes.push_back(run[i]);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        chord_note_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                chord_off[i]  = '0;
                chord_gain[i] = GAIN_UNITY;
            end
            expected_notes.delete();
        end else begin
            if (s_tvalid && s_tready) expand_item(opcode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_notes.size() == 0) begin
                    $error("unexpected result item: m_tdata %h, m_tlast %b", m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    // The result layout matches the first five input fields.
                    want = expected_notes.pop_front();
                    check_field("out_status", want.status, m_tdata[S_STATUS_LSB +: BYTE_W]);
                    check_field("out_key", want.key, m_tdata[S_KEY_LSB +: BYTE_W]);
                    check_field("out_level", want.level, m_tdata[S_LEVEL_LSB +: BYTE_W]);
                    check_field("out_count", want.count, m_tdata[S_COUNT_LSB +: COUNT_W]);
                    check_field("out_time", want.stamp, m_tdata[S_TIME_LSB +: TIME_W]);
                    check_field("last_of_run", want.last, m_tlast);
                end
            end
        end
        outstanding <= expected_notes.size();
    end

endmodule

### tb/sv/tb.sv
// Top of the chord expander testbench: clock, reset, item stimulus, output stalls and verdict.
module tb;
    import mce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    int                  mismatches;
    int                  outstanding;
    int                  burst_left;
    bit                  hold_request;
    bit                  hold_done;

    midi_chord_expander i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    chord_scoreboard i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [S_DATA_W-1:0] pack_item(
        logic [BYTE_W-1:0] status, key, level, logic [COUNT_W-1:0] count,
        logic [TIME_W-1:0] stamp, logic [INDEX_W-1:0] idx, logic [OFF_W-1:0] woff,
        logic [GAIN_W-1:0] wgain);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[S_STATUS_LSB +: BYTE_W] = status;
        d[S_KEY_LSB +: BYTE_W]    = key;
        d[S_LEVEL_LSB +: BYTE_W]  = level;
        d[S_COUNT_LSB +: COUNT_W] = count;
        d[S_TIME_LSB +: TIME_W]   = stamp;
        d[S_INDEX_LSB +: INDEX_W] = idx;
        d[S_OFF_LSB +: OFF_W]     = woff;
        d[S_GAIN_LSB +: GAIN_W]   = wgain;
        return d;
    endfunction

    // The sender offers items in bursts and drops tvalid between them.
    task automatic send_item(opcode_t op, logic [S_DATA_W-1:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    initial begin
        int                  pick;
        int                  tally;
        opcode_t             op;
        logic [BYTE_W-1:0]   status;
        logic [BYTE_W-1:0]   key;
        logic [BYTE_W-1:0]   level;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   stamp;
        logic [INDEX_W-1:0]  idx;
        logic [OFF_W-1:0]    woff;
        logic [GAIN_W-1:0]   wgain;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_EVENT;
        burst_left = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(OP_EVENT, pack_item(8'hF8, 8'd0, 8'd0, 3'd1, 16'h0000, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h90, 8'd60, 8'd100, 3'd3, 16'hFFFF, 6'd0, 5'd0, 8'd0));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd1, 5'd4, 8'd0));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd2, 5'd7, 8'd0));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd3, 5'h14, 8'd0));
        send_item(OP_WRITE_GAIN, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd0, 5'd0, 8'hFF));
        send_item(OP_WRITE_GAIN, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd1, 5'd0, 8'h00));
        send_item(OP_WRITE_GAIN, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd3, 5'd0, 8'd128));
        send_item(OP_EVENT, pack_item(8'h90, 8'd60, 8'd127, 3'd3, 16'h1234, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h80, 8'd0, 8'd64, 3'd3, 16'h0001, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h9F, 8'd120, 8'd255, 3'd3, 16'h8000, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h90, 8'd60, 8'd1, 3'd3, 16'h00FF, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h90, 8'd60, 8'd0, 3'd3, 16'h0F0F, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h90, 8'd60, 8'd90, 3'd2, 16'h0002, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h8A, 8'hFF, 8'd200, 3'd4, 16'h7FFF, 6'd0, 5'd0, 8'd0));
        send_item(OP_UNUSED, pack_item(8'h90, 8'd60, 8'd90, 3'd3, 16'hAAAA, 6'd5, 5'd9, 8'd99));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd63, 5'd5, 8'd0));
        send_item(OP_WRITE_GAIN, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd48, 5'd0, 8'd100));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd47, 5'h0F, 8'd0));
        send_item(OP_WRITE_OFF, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd44, 5'h10, 8'd0));
        send_item(OP_WRITE_GAIN, pack_item(8'h00, 8'd0, 8'd0, 3'd0, 16'h0000, 6'd47, 5'd0, 8'd31));
        send_item(OP_EVENT, pack_item(8'h90, 8'd11, 8'd80, 3'd3, 16'h4321, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'h9C, 8'd127, 8'd128, 3'd7, 16'hFFFE, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'hB0, 8'hFF, 8'hFF, 3'd0, 16'h5555, 6'd0, 5'd0, 8'd0));
        send_item(OP_EVENT, pack_item(8'hA0, 8'd60, 8'd70, 3'd3, 16'h0003, 6'd0, 5'd0, 8'd0));

        hold_request = 1'b1;
        tally = 0;
        while (tally < 95) begin
            pick   = $urandom_range(0, 99);
            status = 8'($urandom);
            key    = 8'($urandom);
            level  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            count  = 3'($urandom);
            stamp  = 16'($urandom);
            idx    = 6'($urandom);
            woff   = 5'($urandom);
            wgain  = 8'($urandom);
            if (pick < 50) begin
                op     = OP_EVENT;
                status = 8'h80 | 8'($urandom_range(0, 31));
                key    = (pick < 45) ? 8'($urandom_range(0, 127)) : key;
                count  = ($urandom_range(0, 9) == 0) ? count : 3'd3;
            end else if (pick < 65) begin
                op = OP_EVENT;
            end else if (pick < 80) begin
                op   = OP_WRITE_OFF;
                idx  = ($urandom_range(0, 9) == 0) ? idx : 6'($urandom_range(0, 47));
                woff = ($urandom_range(0, 7) == 0) ? woff : 5'($urandom_range(0, 24) - 12);
            end else if (pick < 95) begin
                op    = OP_WRITE_GAIN;
                idx   = ($urandom_range(0, 9) == 0) ? idx : 6'($urandom_range(0, 47));
                wgain = ($urandom_range(0, 3) == 0) ? wgain : 8'($urandom_range(32, 128));
            end else begin
                op = OP_UNUSED;
            end
            send_item(op, pack_item(status, key, level, count, stamp, idx, woff, wgain));
            tally++;
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** midi_chord_expander: PASSED **");
        end else begin
            $display("** midi_chord_expander: FAILED **");
        end
        $finish;
    end

    // The receiver changes its stall pattern periodically and holds off once for long.
    initial begin
        int mode;
        int cyc;
        m_tready = 1'b0;
        mode = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                if (cyc % 40 == 0) mode = $urandom_range(0, 3);
                cyc++;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (cyc % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        #1_000_000;
        $display("** midi_chord_expander: FAILED **");
        $finish;
    end

endmodule
